@@ src/scs_pkg.sv @@
`default_nettype none

package scs_pkg;

  localparam int SymW = 8;
  localparam int LcsW = 6;

  typedef enum logic [1:0] {
    KindFirst  = 2'd0,
    KindSecond = 2'd1,
    KindStart  = 2'd2
  } scs_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMPTY,
    S_FROW,
    S_FCELL,
    S_TISSUE,
    S_TCMP,
    S_TUP,
    S_EISSUE,
    S_EOUT
  } scs_state_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [SymW-1:0] symbol;
  } scs_in_beat_t;

  typedef struct packed {
    logic [SymW-1:0] out_symbol;
    logic            last;
    logic            empty_res;
    logic            truncated;
  } scs_out_beat_t;

  typedef struct packed {
    logic          load;
    scs_out_beat_t beat;
  } scs_emit_t;

endpackage

`default_nettype wire

@@ src/shortest_common_supersequence_core.sv @@
// Shortest common supersequence of two byte strings.
// Input channel: each beat carries a kind and a symbol. Kind first or second
// appends the symbol to that string; symbols past MAX_LEN are dropped and
// flagged as truncated on the next result. Kind start runs the computation;
// other kinds are ignored.
// Output channel: one beat per supersequence symbol in forward order, the
// final beat marked last. Two empty strings give one beat flagged empty.
// A start with lengths n and m fills the LCS table one cell per cycle within
// a row, through the table memory's single read port, then walks the
// traceback (one or two table reads per step), then reads the result memory
// for each output beat. Loads run at one per cycle while no start is in progress.
// While a start is in progress in_stall_o is high; the input side is free
// again once the last beat sits in the output register.
// When the receiver stalls, the output register holds its beat and the
// engine waits. Reset clears lengths, overflow flag and output valid; the
// memories are not cleared and need no clearing pass.
`default_nettype none

module shortest_common_supersequence_core #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire scs_pkg::scs_in_beat_t in_beat_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output scs_pkg::scs_out_beat_t     out_beat_o
);

  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TD  = MAX_LEN * MAX_LEN;
  localparam int TAW = (MAX_LEN > 1) ? $clog2(TD) : 1;
  localparam int RD  = 2 * MAX_LEN;
  localparam int RAW = $clog2(RD);

  logic                     a_we, b_we, t_we, r_we;
  logic [IW-1:0]            a_waddr, a_raddr, b_waddr, b_raddr;
  logic [scs_pkg::SymW-1:0] a_wdata, a_rdata, b_wdata, b_rdata, r_wdata, r_rdata;
  logic [TAW-1:0]           t_waddr, t_raddr;
  logic [scs_pkg::LcsW-1:0] t_wdata, t_rdata;
  logic [RAW-1:0]           r_waddr, r_raddr;

  scs_pkg::scs_emit_t     emit;
  scs_pkg::scs_out_beat_t out_beat_q;
  logic                   out_vld_q, out_vld_d, out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  scs_engine #(.MAX_LEN(MAX_LEN)) u_engine (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_beat_i,
    .out_free_i(out_free), .emit_o(emit),
    .a_we_o(a_we), .a_waddr_o(a_waddr), .a_wdata_o(a_wdata),
    .a_raddr_o(a_raddr), .a_rdata_i(a_rdata),
    .b_we_o(b_we), .b_waddr_o(b_waddr), .b_wdata_o(b_wdata),
    .b_raddr_o(b_raddr), .b_rdata_i(b_rdata),
    .t_we_o(t_we), .t_waddr_o(t_waddr), .t_wdata_o(t_wdata),
    .t_raddr_o(t_raddr), .t_rdata_i(t_rdata),
    .r_we_o(r_we), .r_waddr_o(r_waddr), .r_wdata_o(r_wdata),
    .r_raddr_o(r_raddr), .r_rdata_i(r_rdata)
  );

  scs_ram #(.Width(scs_pkg::SymW), .Depth(MAX_LEN), .AddrW(IW)) u_first_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  scs_ram #(.Width(scs_pkg::SymW), .Depth(MAX_LEN), .AddrW(IW)) u_second_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  scs_ram #(.Width(scs_pkg::LcsW), .Depth(TD), .AddrW(TAW)) u_lcs_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  scs_ram #(.Width(scs_pkg::SymW), .Depth(RD), .AddrW(RAW)) u_result_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit.load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      out_beat_q <= emit.beat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

@@ src/scs_ram.sv @@
`default_nettype none

module scs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  parameter int AddrW = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/scs_engine.sv @@
`default_nettype none

module scs_engine #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire scs_pkg::scs_in_beat_t in_beat_i,
  input  wire logic                 out_free_i,
  output scs_pkg::scs_emit_t        emit_o,
  output logic                      a_we_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] a_waddr_o,
  output logic [scs_pkg::SymW-1:0]  a_wdata_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] a_raddr_o,
  input  wire logic [scs_pkg::SymW-1:0] a_rdata_i,
  output logic                      b_we_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] b_waddr_o,
  output logic [scs_pkg::SymW-1:0]  b_wdata_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] b_raddr_o,
  input  wire logic [scs_pkg::SymW-1:0] b_rdata_i,
  output logic                      t_we_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1)-1:0] t_waddr_o,
  output logic [scs_pkg::LcsW-1:0]  t_wdata_o,
  output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1)-1:0] t_raddr_o,
  input  wire logic [scs_pkg::LcsW-1:0] t_rdata_i,
  output logic                      r_we_o,
  output logic [$clog2(2 * MAX_LEN)-1:0] r_waddr_o,
  output logic [scs_pkg::SymW-1:0]  r_wdata_o,
  output logic [$clog2(2 * MAX_LEN)-1:0] r_raddr_o,
  input  wire logic [scs_pkg::SymW-1:0] r_rdata_i
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TAW = (MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;
  localparam int RAW = $clog2(2 * MAX_LEN);
  localparam int CW  = $clog2(2 * MAX_LEN + 1);
  localparam int TW  = scs_pkg::LcsW;

  function automatic logic [TAW-1:0] tidx(input logic [LW-1:0] r, input logic [LW-1:0] c);
    tidx = TAW'((int'(r) - 1) * MAX_LEN + int'(c) - 1);
  endfunction

  scs_pkg::scs_state_e state_q, state_d;
  logic [LW-1:0]  len1_q, len1_d, len2_q, len2_d;
  logic [LW-1:0]  n_q, n_d, m_q, m_d;
  logic [LW-1:0]  r_q, r_d, c_q, c_d;
  logic           ovf_q, ovf_d, trunc_q, trunc_d;
  logic           s1_q, s1_d;
  logic [LW-1:0]  rs_q, rs_d, cs_q, cs_d;
  logic [TW-1:0]  left_q, left_d, diag_q, diag_d, tl_q, tl_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RAW-1:0] eidx_q, eidx_d;

  logic [TW-1:0]  up_v, dg_v, lf_v, cell_v, up_t;
  logic           accept;

  assign accept = in_valid_i && (state_q == scs_pkg::S_IDLE);

  always_comb begin
    up_v   = (rs_q == LW'(1)) ? '0 : t_rdata_i;
    dg_v   = (cs_q == LW'(1)) ? '0 : diag_q;
    lf_v   = (cs_q == LW'(1)) ? '0 : left_q;
    cell_v = (a_rdata_i == b_rdata_i) ? TW'(dg_v + TW'(1)) :
             ((up_v > lf_v) ? up_v : lf_v);
    up_t   = (r_q == LW'(1)) ? '0 : t_rdata_i;
  end

  always_comb begin
    state_d = state_q;
    len1_d  = len1_q;
    len2_d  = len2_q;
    n_d     = n_q;
    m_d     = m_q;
    r_d     = r_q;
    c_d     = c_q;
    ovf_d   = ovf_q;
    trunc_d = trunc_q;
    tl_d    = tl_q;
    cnt_d   = cnt_q;
    eidx_d  = eidx_q;

    s1_d   = (state_q == scs_pkg::S_FCELL);
    rs_d   = r_q;
    cs_d   = c_q;
    left_d = s1_q ? cell_v : left_q;
    diag_d = s1_q ? up_v : diag_q;

    in_stall_o = (state_q != scs_pkg::S_IDLE);

    a_we_o    = 1'b0;
    a_waddr_o = IW'(len1_q);
    a_wdata_o = in_beat_i.symbol;
    a_raddr_o = IW'(r_q - LW'(1));
    b_we_o    = 1'b0;
    b_waddr_o = IW'(len2_q);
    b_wdata_o = in_beat_i.symbol;
    b_raddr_o = IW'(c_q - LW'(1));

    t_we_o    = s1_q;
    t_waddr_o = tidx(rs_q, cs_q);
    t_wdata_o = cell_v;
    t_raddr_o = tidx(r_q, c_q - LW'(1));

    r_we_o    = 1'b0;
    r_waddr_o = RAW'(cnt_q);
    r_wdata_o = a_rdata_i;
    r_raddr_o = eidx_q;

    emit_o                 = '0;
    emit_o.beat.truncated  = trunc_q;
    emit_o.beat.out_symbol = r_rdata_i;

    unique case (state_q)
      scs_pkg::S_IDLE: begin
        if (accept) begin
          case (in_beat_i.kind)
            scs_pkg::KindFirst: begin
              if (len1_q < LW'(MAX_LEN)) begin
                a_we_o = 1'b1;
                len1_d = len1_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            scs_pkg::KindSecond: begin
              if (len2_q < LW'(MAX_LEN)) begin
                b_we_o = 1'b1;
                len2_d = len2_q + LW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            scs_pkg::KindStart: begin
              n_d     = len1_q;
              m_d     = len2_q;
              trunc_d = ovf_q;
              len1_d  = '0;
              len2_d  = '0;
              ovf_d   = 1'b0;
              cnt_d   = '0;
              r_d     = len1_q;
              c_d     = len2_q;
              if (len1_q == '0 && len2_q == '0) begin
                state_d = scs_pkg::S_EMPTY;
              end else if (len1_q == '0 || len2_q == '0) begin
                state_d = scs_pkg::S_TISSUE;
              end else begin
                r_d     = LW'(1);
                state_d = scs_pkg::S_FROW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      scs_pkg::S_EMPTY: begin
        if (out_free_i) begin
          emit_o.load            = 1'b1;
          emit_o.beat.out_symbol = '0;
          emit_o.beat.last       = 1'b1;
          emit_o.beat.empty_res  = 1'b1;
          state_d                = scs_pkg::S_IDLE;
        end
      end
      scs_pkg::S_FROW: begin
        c_d     = LW'(1);
        state_d = scs_pkg::S_FCELL;
      end
      scs_pkg::S_FCELL: begin
        t_raddr_o = tidx(r_q - LW'(1), c_q);
        if (c_q == m_q) begin
          if (r_q == n_q) begin
            state_d = scs_pkg::S_TISSUE;
          end else begin
            r_d     = r_q + LW'(1);
            state_d = scs_pkg::S_FROW;
          end
        end else begin
          c_d = c_q + LW'(1);
        end
      end
      scs_pkg::S_TISSUE: begin
        if (r_q == '0 && c_q == '0) begin
          eidx_d  = RAW'(cnt_q - CW'(1));
          state_d = scs_pkg::S_EISSUE;
        end else begin
          state_d = scs_pkg::S_TCMP;
        end
      end
      scs_pkg::S_TCMP: begin
        if (r_q != '0 && c_q != '0) begin
          if (a_rdata_i == b_rdata_i) begin
            r_we_o  = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            r_d     = r_q - LW'(1);
            c_d     = c_q - LW'(1);
            state_d = scs_pkg::S_TISSUE;
          end else begin
            tl_d      = (c_q == LW'(1)) ? '0 : t_rdata_i;
            t_raddr_o = tidx(r_q - LW'(1), c_q);
            state_d   = scs_pkg::S_TUP;
          end
        end else if (r_q != '0) begin
          r_we_o  = 1'b1;
          cnt_d   = cnt_q + CW'(1);
          r_d     = r_q - LW'(1);
          state_d = scs_pkg::S_TISSUE;
        end else begin
          r_we_o    = 1'b1;
          r_wdata_o = b_rdata_i;
          cnt_d     = cnt_q + CW'(1);
          c_d       = c_q - LW'(1);
          state_d   = scs_pkg::S_TISSUE;
        end
      end
      scs_pkg::S_TUP: begin
        r_we_o = 1'b1;
        cnt_d  = cnt_q + CW'(1);
        if (tl_q < up_t) begin
          r_d = r_q - LW'(1);
        end else begin
          r_wdata_o = b_rdata_i;
          c_d       = c_q - LW'(1);
        end
        state_d = scs_pkg::S_TISSUE;
      end
      scs_pkg::S_EISSUE: begin
        state_d = scs_pkg::S_EOUT;
      end
      scs_pkg::S_EOUT: begin
        if (out_free_i) begin
          emit_o.load      = 1'b1;
          emit_o.beat.last = (eidx_q == '0);
          if (eidx_q == '0) begin
            state_d = scs_pkg::S_IDLE;
          end else begin
            eidx_d  = eidx_q - RAW'(1);
            state_d = scs_pkg::S_EISSUE;
          end
        end
      end
      default: begin
        state_d = scs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scs_pkg::S_IDLE;
      len1_q  <= '0;
      len2_q  <= '0;
      ovf_q   <= 1'b0;
      s1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      ovf_q   <= ovf_d;
      s1_q    <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    m_q     <= m_d;
    r_q     <= r_d;
    c_q     <= c_d;
    trunc_q <= trunc_d;
    rs_q    <= rs_d;
    cs_q    <= cs_d;
    left_q  <= left_d;
    diag_q  <= diag_d;
    tl_q    <= tl_d;
    cnt_q   <= cnt_d;
    eidx_q  <= eidx_d;
  end

endmodule

`default_nettype wire

@@ src/scs_checker.sv @@
`default_nettype none

module scs_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_stall_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire scs_pkg::scs_out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.empty_res |-> out_beat_o.last)
    else $error("empty beat without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.empty_res |-> out_beat_o.out_symbol == '0)
    else $error("empty beat carries a symbol");

  a_busy_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.last |-> in_stall_o)
    else $error("input open in the middle of a result");

endmodule

bind shortest_common_supersequence_core scs_checker u_scs_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_beat_o(out_beat_o)
);

`default_nettype wire
